### sv/uart_rx_ring_xon_xoff_flow_macros.svh
// Assertion macros for the receive ring with XON/XOFF flow control.
`ifndef UART_RX_RING_XON_XOFF_FLOW_MACROS_SVH
`define UART_RX_RING_XON_XOFF_FLOW_MACROS_SVH

`ifndef SYNTHESIS
`define URX_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("uartrx assertion failed");
`define URX_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("uartrx assertion failed");
`else
`define URX_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define URX_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

### sv/uartrx_pkg.sv
// Shared types and constants of the receive ring with XON/XOFF flow control.
package uartrx_pkg;

	localparam int RING_DEPTH = 2048;
	localparam int PTR_W      = $clog2(RING_DEPTH);
	localparam int MARK_W     = 11;
	localparam int FILL_W     = (PTR_W > MARK_W) ? PTR_W : MARK_W;
	localparam int DATA_W     = 8;
	localparam int MODE_W     = 3;
	localparam int CFG_IDX_W  = 3;

	localparam logic [DATA_W-1:0] XON_BYTE      = 8'h11;
	localparam logic [DATA_W-1:0] XOFF_BYTE     = 8'h13;
	localparam logic [MARK_W-1:0] HIGH_MARK_RST = 11'd1536;
	localparam logic [MARK_W-1:0] LOW_MARK_RST  = 11'd512;

	typedef enum logic [MODE_W-1:0] {
		MODE_LINE_BYTE = 3'd0,
		MODE_HOST_POP  = 3'd1,
		MODE_PURGE     = 3'd2,
		MODE_TX_EMPTY  = 3'd3,
		MODE_LINE_ERR  = 3'd4
	} mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_XON_FLOW_EN = 3'd0,
		CFG_HW_FLOW_EN  = 3'd1,
		CFG_HIGH_MARK   = 3'd2,
		CFG_LOW_MARK    = 3'd3
	} cfg_idx_t;

	typedef enum logic [1:0] {
		ST_IDLE = 2'd0,
		ST_EXEC = 2'd1,
		ST_FLOW = 2'd2
	} state_t;

	typedef struct packed {
		logic capture;
		logic execute;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic result_free;
	} status_t;

endpackage

### sv/uartrx_ifs.sv
// Request, result and configuration channel interfaces.
interface uartrx_in_if;
	logic                          valid;
	logic                          ready;
	logic [uartrx_pkg::MODE_W-1:0] mode;
	logic [uartrx_pkg::DATA_W-1:0] rx_byte;
	logic                          tx_holding_empty;

	modport source (output valid, output mode, output rx_byte, output tx_holding_empty,
		input ready);
	modport sink (input valid, input mode, input rx_byte, input tx_holding_empty,
		output ready);
endinterface

interface uartrx_out_if;
	logic                          valid;
	logic                          ready;
	logic                          read_valid;
	logic [uartrx_pkg::DATA_W-1:0] read_byte;
	logic                          flow_send_valid;
	logic [uartrx_pkg::DATA_W-1:0] flow_send_byte;
	logic                          flow_pending;
	logic                          rts_level;
	logic                          remote_paused;
	logic                          error_flag;
	logic [uartrx_pkg::MARK_W-1:0] fill_count;

	modport source (output valid, output read_valid, output read_byte,
		output flow_send_valid, output flow_send_byte, output flow_pending,
		output rts_level, output remote_paused, output error_flag, output fill_count,
		input ready);
	modport sink (input valid, input read_valid, input read_byte,
		input flow_send_valid, input flow_send_byte, input flow_pending,
		input rts_level, input remote_paused, input error_flag, input fill_count,
		output ready);
endinterface

interface uartrx_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [uartrx_pkg::CFG_IDX_W-1:0] index;
	logic [uartrx_pkg::MARK_W-1:0]    data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

### sv/uartrx_ram.sv
// Generic single-write, single-read RAM with registered read data.
module uartrx_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### sv/uartrx_ctrl.sv
// Controller: sequences capture, ring update and flow check for each request.
module uartrx_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  uartrx_pkg::status_t status,
	output uartrx_pkg::cmd_t    cmd
);

	uartrx_pkg::state_t state_q;
	uartrx_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= uartrx_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			uartrx_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_d = uartrx_pkg::ST_EXEC;
				end
			end
			uartrx_pkg::ST_EXEC: begin
				state_d = uartrx_pkg::ST_FLOW;
			end
			uartrx_pkg::ST_FLOW: begin
				// hold until the result register can take the new result
				if (status.result_free) begin
					state_d = uartrx_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = uartrx_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		in_ready    = 1'b0;
		cmd.capture = 1'b0;
		cmd.execute = 1'b0;
		cmd.finish  = 1'b0;
		case (state_q)
			uartrx_pkg::ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
			end
			uartrx_pkg::ST_EXEC: begin
				cmd.execute = 1'b1;
			end
			uartrx_pkg::ST_FLOW: begin
				cmd.finish = status.result_free;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

endmodule

### sv/uartrx_dp.sv
// Datapath: ring pointers, flow state, configuration and result register.
module uartrx_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  uartrx_pkg::cmd_t              cmd,
	output uartrx_pkg::status_t           status,
	input  logic [uartrx_pkg::MODE_W-1:0] mode,
	input  logic [uartrx_pkg::DATA_W-1:0] rx_byte,
	input  logic                          tx_holding_empty,
	uartrx_out_if.source                  rx_res,
	uartrx_cfg_if.sink                    cfg
);

	localparam logic [uartrx_pkg::PTR_W-1:0] PTR_LAST =
		uartrx_pkg::PTR_W'(uartrx_pkg::RING_DEPTH - 1);
	localparam logic [uartrx_pkg::FILL_W:0] DEPTH_EXT =
		(uartrx_pkg::FILL_W + 1)'(uartrx_pkg::RING_DEPTH);

	// configuration
	logic                          xon_en_q;
	logic                          hw_en_q;
	logic [uartrx_pkg::MARK_W-1:0] high_q;
	logic [uartrx_pkg::MARK_W-1:0] low_q;

	// captured request
	logic [uartrx_pkg::MODE_W-1:0] mode_s1;
	logic [uartrx_pkg::DATA_W-1:0] byte_s1;
	logic                          txe_s1;

	// ring and flow state
	logic [uartrx_pkg::PTR_W-1:0] wr_q;
	logic [uartrx_pkg::PTR_W-1:0] rd_q;
	logic                         err_q;
	logic                         pause_q;
	logic                         pend_q;
	logic                         pend_xoff_q;
	logic                         rts_q;

	// update results carried to the flow check
	logic                          rdv_s2;
	logic [uartrx_pkg::DATA_W-1:0] rdb_s2;
	logic                          snd_s2;
	logic                          sndx_s2;
	logic                          check_s2;

	// result register
	logic                          res_valid_q;
	logic                          res_rdv_q;
	logic [uartrx_pkg::DATA_W-1:0] res_rdb_q;
	logic                          res_snd_q;
	logic [uartrx_pkg::DATA_W-1:0] res_sndb_q;
	logic                          res_pend_q;
	logic                          res_rts_q;
	logic                          res_pause_q;
	logic                          res_err_q;
	logic [uartrx_pkg::MARK_W-1:0] res_fill_q;

	// ring memory
	logic                          ram_we;
	logic [uartrx_pkg::DATA_W-1:0] ram_rdata;

	// update step
	logic [uartrx_pkg::PTR_W-1:0]  wr_nx;
	logic [uartrx_pkg::PTR_W-1:0]  rd_nx;
	logic [uartrx_pkg::PTR_W-1:0]  e_wr;
	logic [uartrx_pkg::PTR_W-1:0]  e_rd;
	logic                          e_err;
	logic                          e_pause;
	logic                          e_pend;
	logic                          e_rdv;
	logic [uartrx_pkg::DATA_W-1:0] e_rdb;
	logic                          e_snd;
	logic                          e_sndx;
	logic                          e_check;

	// flow check step
	logic [uartrx_pkg::FILL_W:0]   fill_sum;
	logic [uartrx_pkg::FILL_W-1:0] fill;
	logic                          ge_hi;
	logic                          le_lo;
	logic                          f_pend;
	logic                          f_pend_xoff;
	logic                          f_snd;
	logic                          f_sndx;
	logic                          f_rts;
	logic [uartrx_pkg::DATA_W-1:0] f_sndb;
	logic [uartrx_pkg::DATA_W-1:0] f_rdb;

	assign wr_nx = (wr_q == PTR_LAST) ? '0 : wr_q + 1'b1;
	assign rd_nx = (rd_q == PTR_LAST) ? '0 : rd_q + 1'b1;

	uartrx_ram #(
		.WIDTH(uartrx_pkg::DATA_W),
		.DEPTH(uartrx_pkg::RING_DEPTH)
	) u_ring (
		.clk  (clk),
		.we   (ram_we),
		.waddr(wr_q),
		.wdata(byte_s1),
		.re   (cmd.capture),
		.raddr(rd_q),
		.rdata(ram_rdata)
	);

	always_comb begin
		e_wr    = wr_q;
		e_rd    = rd_q;
		e_err   = err_q;
		e_pause = pause_q;
		e_pend  = pend_q;
		e_rdv   = 1'b0;
		e_rdb   = '0;
		e_snd   = 1'b0;
		e_sndx  = 1'b0;
		e_check = 1'b0;
		ram_we  = 1'b0;
		case (uartrx_pkg::mode_t'(mode_s1))
			uartrx_pkg::MODE_LINE_BYTE: begin
				e_check = 1'b1;
				if (xon_en_q && byte_s1 == uartrx_pkg::XOFF_BYTE) begin
					e_pause = 1'b1;
				end else if (xon_en_q && byte_s1 == uartrx_pkg::XON_BYTE) begin
					e_pause = 1'b0;
				end else if (wr_nx == rd_q) begin
					// ring full: drop the byte
					e_err = 1'b1;
				end else begin
					ram_we = cmd.execute;
					e_wr   = wr_nx;
				end
			end
			uartrx_pkg::MODE_HOST_POP: begin
				if (!err_q) begin
					e_check = 1'b1;
					if (rd_q != wr_q) begin
						e_rdv = 1'b1;
						e_rdb = ram_rdata;
						e_rd  = rd_nx;
					end
				end
			end
			uartrx_pkg::MODE_PURGE: begin
				e_wr    = '0;
				e_rd    = '0;
				e_err   = 1'b0;
				e_check = 1'b1;
			end
			uartrx_pkg::MODE_TX_EMPTY: begin
				if (pend_q) begin
					e_snd  = 1'b1;
					e_sndx = pend_xoff_q;
					e_pend = 1'b0;
				end
			end
			uartrx_pkg::MODE_LINE_ERR: begin
				e_err = 1'b1;
			end
			default: begin
				e_check = 1'b0;
			end
		endcase
	end

	always_comb begin
		if (wr_q >= rd_q) begin
			fill_sum = (uartrx_pkg::FILL_W + 1)'(wr_q) - (uartrx_pkg::FILL_W + 1)'(rd_q);
		end else begin
			fill_sum = (uartrx_pkg::FILL_W + 1)'(wr_q) + DEPTH_EXT
				- (uartrx_pkg::FILL_W + 1)'(rd_q);
		end
		fill  = fill_sum[uartrx_pkg::FILL_W-1:0];
		ge_hi = fill >= uartrx_pkg::FILL_W'(high_q);
		le_lo = fill <= uartrx_pkg::FILL_W'(low_q);

		f_pend      = pend_q;
		f_pend_xoff = pend_xoff_q;
		f_snd       = snd_s2;
		f_sndx      = sndx_s2;
		f_rts       = rts_q;
		if (check_s2 && (ge_hi || le_lo)) begin
			// high mark wins over low mark
			if (xon_en_q && !(pend_q && pend_xoff_q == ge_hi)) begin
				f_pend_xoff = ge_hi;
				if (txe_s1) begin
					f_snd  = 1'b1;
					f_sndx = ge_hi;
					f_pend = 1'b0;
				end else begin
					f_pend = 1'b1;
				end
			end
			if (hw_en_q) begin
				f_rts = !ge_hi;
			end
		end
		if (!f_snd) begin
			f_sndb = '0;
		end else if (f_sndx) begin
			f_sndb = uartrx_pkg::XOFF_BYTE;
		end else begin
			f_sndb = uartrx_pkg::XON_BYTE;
		end
		f_rdb = rdv_s2 ? rdb_s2 : '0;
	end

	assign status.result_free = !res_valid_q || rx_res.ready;

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			xon_en_q    <= 1'b0;
			hw_en_q     <= 1'b0;
			high_q      <= uartrx_pkg::HIGH_MARK_RST;
			low_q       <= uartrx_pkg::LOW_MARK_RST;
			wr_q        <= '0;
			rd_q        <= '0;
			err_q       <= 1'b0;
			pause_q     <= 1'b0;
			pend_q      <= 1'b0;
			pend_xoff_q <= 1'b0;
			rts_q       <= 1'b1;
			res_valid_q <= 1'b0;
		end else begin
			if (cfg.valid) begin
				case (uartrx_pkg::cfg_idx_t'(cfg.index))
					uartrx_pkg::CFG_XON_FLOW_EN: xon_en_q <= cfg.data[0];
					uartrx_pkg::CFG_HW_FLOW_EN:  hw_en_q  <= cfg.data[0];
					uartrx_pkg::CFG_HIGH_MARK:   high_q   <= cfg.data;
					uartrx_pkg::CFG_LOW_MARK:    low_q    <= cfg.data;
					default: begin
						xon_en_q <= xon_en_q;
					end
				endcase
			end
			if (cmd.execute) begin
				wr_q    <= e_wr;
				rd_q    <= e_rd;
				err_q   <= e_err;
				pause_q <= e_pause;
				pend_q  <= e_pend;
			end else if (cmd.finish) begin
				pend_q      <= f_pend;
				pend_xoff_q <= f_pend_xoff;
				rts_q       <= f_rts;
			end
			if (cmd.finish) begin
				res_valid_q <= 1'b1;
			end else if (rx_res.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			mode_s1 <= mode;
			byte_s1 <= rx_byte;
			txe_s1  <= tx_holding_empty;
		end
		if (cmd.execute) begin
			rdv_s2   <= e_rdv;
			rdb_s2   <= e_rdb;
			snd_s2   <= e_snd;
			sndx_s2  <= e_sndx;
			check_s2 <= e_check;
		end
		if (cmd.finish) begin
			res_rdv_q   <= rdv_s2;
			res_rdb_q   <= f_rdb;
			res_snd_q   <= f_snd;
			res_sndb_q  <= f_sndb;
			res_pend_q  <= f_pend;
			res_rts_q   <= f_rts;
			res_pause_q <= pause_q;
			res_err_q   <= err_q;
			res_fill_q  <= fill[uartrx_pkg::MARK_W-1:0];
		end
	end

	assign cfg.ready              = 1'b1;
	assign rx_res.valid           = res_valid_q;
	assign rx_res.read_valid      = res_rdv_q;
	assign rx_res.read_byte       = res_rdb_q;
	assign rx_res.flow_send_valid = res_snd_q;
	assign rx_res.flow_send_byte  = res_sndb_q;
	assign rx_res.flow_pending    = res_pend_q;
	assign rx_res.rts_level       = res_rts_q;
	assign rx_res.remote_paused   = res_pause_q;
	assign rx_res.error_flag      = res_err_q;
	assign rx_res.fill_count      = res_fill_q;

endmodule

### sv/uart_rx_ring_xon_xoff_flow.sv
// Top level: UART receive ring with XON/XOFF and RTS flow control.
// Flow: an accepted request is captured, then the ring is updated, then the flow check
// registers the result, holding while the result register is full; no new request is taken
// until then. The controller steps capture with ring read, ring update and flow check.
// Reset: pointers, error, pause, pending flow byte clear, RTS asserted, marks
// 1536/512; ring contents are not cleared and need no clearing pass.
`include "uart_rx_ring_xon_xoff_flow_macros.svh"

module uart_rx_ring_xon_xoff_flow (
	input logic         clk,
	input logic         arst_n,
	uartrx_in_if.sink   rx_req,
	uartrx_out_if.source rx_res,
	uartrx_cfg_if.sink  cfg
);

	uartrx_pkg::cmd_t    cmd;
	uartrx_pkg::status_t status;
	logic                in_ready;

	assign rx_req.ready = in_ready;

	uartrx_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(rx_req.valid),
		.in_ready(in_ready),
		.status  (status),
		.cmd     (cmd)
	);

	uartrx_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.status          (status),
		.mode            (rx_req.mode),
		.rx_byte         (rx_req.rx_byte),
		.tx_holding_empty(rx_req.tx_holding_empty),
		.rx_res          (rx_res),
		.cfg             (cfg)
	);

	`URX_ASSERT_NEXT(a_accept_then_busy, clk, arst_n, rx_req.valid && rx_req.ready, !rx_req.ready)
	`URX_ASSERT_NEXT(a_capture_then_exec, clk, arst_n, cmd.capture, cmd.execute)
	`URX_ASSERT_SAME(a_finish_needs_room, clk, arst_n, cmd.finish, status.result_free)
	`URX_ASSERT_NEXT(a_finish_gives_result, clk, arst_n, cmd.finish, rx_res.valid)

endmodule

### tb/sv/rx_flow_checker.sv
// Checker for the receive ring: predicts each result from accepted requests and compares.
module rx_flow_checker
	import uartrx_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	uartrx_in_if         req,
	uartrx_out_if        res,
	uartrx_cfg_if        cfg,
	output int           fail_count,
	output int           owed,
	output int           results_checked,
	output int           flow_bytes_sent,
	output int           overflow_drops
);

	typedef struct packed {
		logic              rd_v;
		logic [DATA_W-1:0] rd_b;
		logic              snd_v;
		logic [DATA_W-1:0] snd_b;
		logic              pend;
		logic              rts;
		logic              paused;
		logic              err;
		logic [MARK_W-1:0] fill;
	} ring_result_t;

	ring_result_t due_results[$];

	logic [DATA_W-1:0] ring_mem [RING_DEPTH];
	int   wr_ptr;
	int   rd_ptr;
	logic err;
	logic paused;
	logic pend_v;
	logic pend_xoff;
	logic rts_now;
	logic xon_en;
	logic hw_en;
	int   high_mark;
	int   low_mark;
	logic flow_now;
	logic [DATA_W-1:0] flow_byte;

	function automatic int ring_fill();
		if (wr_ptr >= rd_ptr)
			return wr_ptr - rd_ptr;
		return wr_ptr + RING_DEPTH - rd_ptr;
	endfunction

	function automatic void ask_flow_byte(logic want_xoff, logic txe);
		if (!xon_en)
			return;
		if (pend_v && pend_xoff == want_xoff)
			return;
		pend_v = 1'b1;
		pend_xoff = want_xoff;
		if (txe) begin
			flow_now = 1'b1;
			flow_byte = want_xoff ? XOFF_BYTE : XON_BYTE;
			pend_v = 1'b0;
		end
	endfunction

	function automatic void check_marks(logic txe);
		int n;
		n = ring_fill();
		if (n >= high_mark) begin
			ask_flow_byte(1'b1, txe);
			if (hw_en)
				rts_now = 1'b0;
		end else if (n <= low_mark) begin
			ask_flow_byte(1'b0, txe);
			if (hw_en)
				rts_now = 1'b1;
		end
	endfunction

	function automatic ring_result_t step_ring(mode_t mode, logic [DATA_W-1:0] b, logic txe);
		ring_result_t r;
		int nxt;
		r = '0;
		flow_now = 1'b0;
		flow_byte = '0;
		case (mode)
			MODE_LINE_BYTE: begin
				if (xon_en && b == XOFF_BYTE) begin
					paused = 1'b1;
				end else if (xon_en && b == XON_BYTE) begin
					paused = 1'b0;
				end else begin
					nxt = (wr_ptr + 1) % RING_DEPTH;
					// ring keeps one slot free: drop the byte when full
					if (nxt == rd_ptr) begin
						err = 1'b1;
						overflow_drops++;
					end else begin
						ring_mem[wr_ptr] = b;
						wr_ptr = nxt;
					end
				end
				check_marks(txe);
			end
			MODE_HOST_POP: begin
				if (!err) begin
					if (rd_ptr != wr_ptr) begin
						r.rd_v = 1'b1;
						r.rd_b = ring_mem[rd_ptr];
						rd_ptr = (rd_ptr + 1) % RING_DEPTH;
					end
					check_marks(txe);
				end
			end
			MODE_PURGE: begin
				wr_ptr = 0;
				rd_ptr = 0;
				err = 1'b0;
				check_marks(txe);
			end
			MODE_TX_EMPTY: begin
				if (pend_v) begin
					flow_now = 1'b1;
					flow_byte = pend_xoff ? XOFF_BYTE : XON_BYTE;
					pend_v = 1'b0;
				end
			end
			MODE_LINE_ERR: err = 1'b1;
			default: ;
		endcase
		if (flow_now)
			flow_bytes_sent++;
		r.snd_v = flow_now;
		r.snd_b = flow_byte;
		r.pend = pend_v;
		r.rts = rts_now;
		r.paused = paused;
		r.err = err;
		r.fill = MARK_W'(ring_fill());
		return r;
	endfunction

	function automatic void check_field(string label, logic [MARK_W-1:0] want,
		logic [MARK_W-1:0] got);
		if (got !== want) begin
			fail_count++;
			$display("%0t: %s mismatch: expected %0d, actual %0d", $time, label, want, got);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		ring_result_t got;
		ring_result_t want;
		if (!arst_n) begin
			wr_ptr = 0;
			rd_ptr = 0;
			err = 1'b0;
			paused = 1'b0;
			pend_v = 1'b0;
			pend_xoff = 1'b0;
			rts_now = 1'b1;
			xon_en = 1'b0;
			hw_en = 1'b0;
			high_mark = HIGH_MARK_RST;
			low_mark = LOW_MARK_RST;
			due_results.delete();
			owed = 0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg_idx_t'(cfg.index))
					CFG_XON_FLOW_EN: xon_en = cfg.data[0];
					CFG_HW_FLOW_EN:  hw_en = cfg.data[0];
					CFG_HIGH_MARK:   high_mark = cfg.data;
					CFG_LOW_MARK:    low_mark = cfg.data;
					default: ;
				endcase
			end
			// results come out in order: retire the oldest prediction first
			if (res.valid && res.ready) begin
				results_checked++;
				got = '{res.read_valid, res.read_byte, res.flow_send_valid, res.flow_send_byte,
					res.flow_pending, res.rts_level, res.remote_paused, res.error_flag,
					res.fill_count};
				if (due_results.size() == 0) begin
					fail_count++;
					$display("%0t: result with no request waiting, fill %0d", $time,
						res.fill_count);
				end else begin
					want = due_results.pop_front();
					check_field("read_valid", MARK_W'(want.rd_v), MARK_W'(got.rd_v));
					check_field("read_byte", MARK_W'(want.rd_b), MARK_W'(got.rd_b));
					check_field("flow_send_valid", MARK_W'(want.snd_v), MARK_W'(got.snd_v));
					check_field("flow_send_byte", MARK_W'(want.snd_b), MARK_W'(got.snd_b));
					check_field("flow_pending", MARK_W'(want.pend), MARK_W'(got.pend));
					check_field("rts_level", MARK_W'(want.rts), MARK_W'(got.rts));
					check_field("remote_paused", MARK_W'(want.paused), MARK_W'(got.paused));
					check_field("error_flag", MARK_W'(want.err), MARK_W'(got.err));
					check_field("fill_count", want.fill, got.fill);
				end
			end
			if (req.valid && req.ready)
				due_results.push_back(step_ring(mode_t'(req.mode), req.rx_byte,
					req.tx_holding_empty));
			owed = due_results.size();
		end
	end

endmodule

### tb/sv/testbench.sv
// Top of the receive ring testbench: clock, reset, request and config stimulus, verdict.
module testbench;
	import uartrx_pkg::*;

	localparam int CYCLE_LIMIT = 600000;
	localparam int RANDOM_ITEMS = 1040;

	logic clk;
	logic arst_n;
	int   cycles;
	int   req_gap_max;
	int   res_gap_max;
	int   sent_count;
	int   settings_count;
	int   fail_count;
	int   owed;
	int   results_checked;
	int   flow_bytes_sent;
	int   overflow_drops;

	uartrx_in_if  rx_req ();
	uartrx_out_if rx_res ();
	uartrx_cfg_if cfg ();

	uart_rx_ring_xon_xoff_flow dut (
		.clk    (clk),
		.arst_n (arst_n),
		.rx_req (rx_req),
		.rx_res (rx_res),
		.cfg    (cfg)
	);

	rx_flow_checker checker_i (
		.clk             (clk),
		.arst_n          (arst_n),
		.req             (rx_req),
		.res             (rx_res),
		.cfg             (cfg),
		.fail_count      (fail_count),
		.owed            (owed),
		.results_checked (results_checked),
		.flow_bytes_sent (flow_bytes_sent),
		.overflow_drops  (overflow_drops)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d results still owed", cycles, owed);
			$display("Regression FAIL");
			$finish;
		end
	end

	// result side: stall a random number of cycles before each result
	initial begin
		int stall;
		rx_res.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = $urandom_range(0, res_gap_max);
			if (stall != 0) begin
				rx_res.ready = 1'b0;
				repeat (stall) @(negedge clk);
			end
			rx_res.ready = 1'b1;
			do @(posedge clk); while (!(rx_res.valid && rx_res.ready));
			@(negedge clk);
		end
	end

	task automatic send_request(mode_t m, logic [DATA_W-1:0] b, logic txe);
		int gap;
		gap = $urandom_range(0, req_gap_max);
		if (gap != 0) begin
			rx_req.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		rx_req.mode = m;
		rx_req.rx_byte = b;
		rx_req.tx_holding_empty = txe;
		rx_req.valid = 1'b1;
		do @(posedge clk); while (!(rx_req.valid && rx_req.ready));
		@(negedge clk);
		sent_count++;
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [MARK_W-1:0] value);
		cfg.index = idx;
		cfg.data = value;
		cfg.valid = 1'b1;
		do @(posedge clk); while (!(cfg.valid && cfg.ready));
		@(negedge clk);
	endtask

	// drain every owed result, then reprogram all four registers
	task automatic program_flow(logic xon, logic hw, int hi, int lo);
		rx_req.valid = 1'b0;
		while (owed != 0) @(negedge clk);
		write_reg(CFG_XON_FLOW_EN, MARK_W'(xon));
		write_reg(CFG_HW_FLOW_EN, MARK_W'(hw));
		write_reg(CFG_HIGH_MARK, MARK_W'(hi));
		write_reg(CFG_LOW_MARK, MARK_W'(lo));
		cfg.valid = 1'b0;
		settings_count++;
	endtask

	function automatic logic [DATA_W-1:0] line_byte();
		if ($urandom_range(0, 5) == 0)
			return $urandom_range(0, 1) ? XON_BYTE : XOFF_BYTE;
		return DATA_W'($urandom_range(0, 255));
	endfunction

	task automatic random_request(int push_pct);
		int r;
		logic txe;
		r = $urandom_range(0, 99);
		txe = 1'($urandom_range(0, 1));
		if (r < push_pct)
			send_request(MODE_LINE_BYTE, line_byte(), txe);
		else if (r < 88)
			send_request(MODE_HOST_POP, DATA_W'($urandom_range(0, 255)), txe);
		else if (r < 95)
			send_request(MODE_TX_EMPTY, DATA_W'($urandom_range(0, 255)), txe);
		else if (r < 98)
			send_request(MODE_PURGE, DATA_W'($urandom_range(0, 255)), txe);
		else
			send_request(MODE_LINE_ERR, DATA_W'($urandom_range(0, 255)), txe);
	endtask

	initial begin
		int random_done;
		int hi;
		int lo;
		int n;
		int push_pct;
		arst_n = 1'b0;
		rx_req.valid = 1'b0;
		rx_req.mode = MODE_LINE_BYTE;
		rx_req.rx_byte = '0;
		rx_req.tx_holding_empty = 1'b0;
		cfg.valid = 1'b0;
		cfg.index = CFG_XON_FLOW_EN;
		cfg.data = '0;
		req_gap_max = 7;
		res_gap_max = 7;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;

		// directed: tiny marks so every flow path shows up within a few bytes
		program_flow(1'b1, 1'b1, 4, 1);
		send_request(MODE_LINE_BYTE, 8'h00, 1'b1);
		send_request(MODE_LINE_BYTE, 8'hFF, 1'b0);
		send_request(MODE_LINE_BYTE, XOFF_BYTE, 1'b1);
		send_request(MODE_LINE_BYTE, XON_BYTE, 1'b1);
		send_request(MODE_LINE_BYTE, 8'h5A, 1'b0);
		send_request(MODE_LINE_BYTE, 8'hA5, 1'b0);
		send_request(MODE_LINE_BYTE, XOFF_BYTE, 1'b0);
		send_request(MODE_TX_EMPTY, 8'h00, 1'b0);
		send_request(MODE_TX_EMPTY, 8'hFF, 1'b1);
		send_request(MODE_HOST_POP, 8'h00, 1'b1);
		send_request(MODE_HOST_POP, 8'h00, 1'b0);
		send_request(MODE_HOST_POP, 8'h00, 1'b0);
		send_request(MODE_LINE_BYTE, 8'h7E, 1'b1);
		send_request(MODE_LINE_BYTE, 8'h81, 1'b0);
		send_request(MODE_LINE_BYTE, 8'h3C, 1'b1);
		send_request(MODE_LINE_ERR, 8'h00, 1'b0);
		send_request(MODE_HOST_POP, 8'h00, 1'b1);
		send_request(MODE_LINE_BYTE, XON_BYTE, 1'b0);
		send_request(MODE_PURGE, 8'h00, 1'b0);
		send_request(MODE_HOST_POP, 8'h00, 1'b1);
		send_request(MODE_TX_EMPTY, 8'h00, 1'b0);
		send_request(MODE_HOST_POP, 8'h00, 1'b1);

		random_done = 0;
		while (random_done < RANDOM_ITEMS) begin
			case ($urandom_range(0, 6))
				0: begin hi = 0; lo = 0; end
				1: begin hi = 2047; lo = 2047; end
				2: begin hi = 2047; lo = 0; end
				3: begin hi = $urandom_range(1, 24); lo = $urandom_range(0, 30); end
				default: begin hi = $urandom_range(1, 24); lo = $urandom_range(0, hi); end
			endcase
			program_flow(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), hi, lo);
			req_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 7;
			res_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 7;
			push_pct = $urandom_range(35, 65);
			n = $urandom_range(40, 120);
			repeat (n) random_request(push_pct);
			random_done += n;
		end

		rx_req.valid = 1'b0;
		while (owed != 0) @(negedge clk);
		repeat (8) @(negedge clk);

		$display("Sent %0d requests under %0d register settings; %0d results compared.",
			sent_count, settings_count, results_checked);
		$display("Full-ring drops seen: %0d; flow bytes sent to the transmitter: %0d.",
			overflow_drops, flow_bytes_sent);
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
